[sv/bnnd_pkg.sv]
// ----------------------------------------------------------------------------
// bnnd_pkg - shared types and constants for the Bayer demosaic block
// Register map, site codes and the position flags passed to the pipeline.
// ----------------------------------------------------------------------------
package bnnd_pkg;

   // configuration registers
   localparam int CFG_W           = 13;
   localparam int CSR_DATA_W      = 32;
   localparam int CSR_ADDR_W      = 3;
   localparam int LINE_LENGTH_RST = 640;
   localparam int LINE_COUNT_RST  = 480;

   // line counter
   localparam int LINE_POS_W      = 12;
   localparam int MAX_LINE_COUNT  = 4096;
   localparam int MIN_DIM         = 2;

   typedef enum logic {
      CSR_LINE_LENGTH = 1'b0,
      CSR_LINE_COUNT  = 1'b1
   } csr_reg_type;

   // colour of the output site, coded {odd line, odd pixel}
   typedef enum logic [1:0] {
      SITE_GB_GREEN = 2'b00,
      SITE_BLUE     = 2'b01,
      SITE_RED      = 2'b10,
      SITE_RG_GREEN = 2'b11
   } site_type;

   typedef struct packed {
      logic     emit;
      site_type site;
      logic     frame_end;
   } pos_info_type;

endpackage

[sv/bnnd_ram.sv]
// ----------------------------------------------------------------------------
// bnnd_ram - generic single-clock RAM
// One write port, one read port, registered read data, read-first.
// ----------------------------------------------------------------------------
module bnnd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/bnnd_position.sv]
// ----------------------------------------------------------------------------
// bnnd_position - raster position counters
// Clamps the frame size and tracks line / pixel of the next request.
// ----------------------------------------------------------------------------
module bnnd_position #(
   parameter int MAX_LINE_LENGTH = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic [bnnd_pkg::CFG_W-1:0]         line_length,
   input  logic [bnnd_pkg::CFG_W-1:0]         line_count,
   output logic [$clog2(MAX_LINE_LENGTH)-1:0] pixel_pos,
   output bnnd_pkg::pos_info_type             info
);

   localparam int PIX_W = $clog2(MAX_LINE_LENGTH);
   localparam int LEN_W = (PIX_W + 1 > bnnd_pkg::CFG_W) ? PIX_W + 1 : bnnd_pkg::CFG_W;
   localparam int LIN_W = bnnd_pkg::LINE_POS_W + 1;

   logic [PIX_W-1:0]                    pixel_pos_ff, pixel_pos_in;
   logic [bnnd_pkg::LINE_POS_W-1:0]     line_pos_ff, line_pos_in;
   logic [LEN_W-1:0]                    len_raw, len_eff;
   logic [LIN_W-1:0]                    cnt_eff;
   logic                                last_pix, last_line;

   // saturate the frame size registers
   always_comb begin
      len_raw = LEN_W'(line_length);
      if (len_raw < LEN_W'(bnnd_pkg::MIN_DIM)) begin
         len_eff = LEN_W'(bnnd_pkg::MIN_DIM);
      end else if (len_raw > LEN_W'(MAX_LINE_LENGTH)) begin
         len_eff = LEN_W'(MAX_LINE_LENGTH);
      end else begin
         len_eff = len_raw;
      end
      if (line_count < bnnd_pkg::CFG_W'(bnnd_pkg::MIN_DIM)) begin
         cnt_eff = LIN_W'(bnnd_pkg::MIN_DIM);
      end else if (LIN_W'(line_count) > LIN_W'(bnnd_pkg::MAX_LINE_COUNT)) begin
         cnt_eff = LIN_W'(bnnd_pkg::MAX_LINE_COUNT);
      end else begin
         cnt_eff = LIN_W'(line_count);
      end
   end

   assign last_pix  = (LEN_W'(pixel_pos_ff) + LEN_W'(1)) >= len_eff;
   assign last_line = (LIN_W'(line_pos_ff) + LIN_W'(1)) >= cnt_eff;

   always_comb begin
      pixel_pos_in = pixel_pos_ff;
      line_pos_in  = line_pos_ff;
      if (advance) begin
         if (last_pix) begin
            pixel_pos_in = '0;
            line_pos_in  = last_line ? '0 : line_pos_ff + 1'b1;
         end else begin
            pixel_pos_in = pixel_pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_pos_ff <= '0;
         line_pos_ff  <= '0;
      end else begin
         pixel_pos_ff <= pixel_pos_in;
         line_pos_ff  <= line_pos_in;
      end
   end

   // window output sits one line up and one pixel left
   assign pixel_pos      = pixel_pos_ff;
   assign info.emit      = (line_pos_ff != '0) && (pixel_pos_ff != '0);
   assign info.site      = bnnd_pkg::site_type'({~line_pos_ff[0], ~pixel_pos_ff[0]});
   assign info.frame_end = last_pix && last_line;

endmodule

[sv/bnnd_select.sv]
// ----------------------------------------------------------------------------
// bnnd_select - colour selection and result register
// Picks R, G, B from the 2x2 window by site colour and holds the response.
// ----------------------------------------------------------------------------
module bnnd_select #(
   parameter int SAMPLE_BITS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  bnnd_pkg::site_type     site,
   input  logic                   frame_end,
   input  logic [SAMPLE_BITS-1:0] s00,
   input  logic [SAMPLE_BITS-1:0] s01,
   input  logic [SAMPLE_BITS-1:0] s10,
   input  logic [SAMPLE_BITS-1:0] s11,
   output logic                   free,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SAMPLE_BITS-1:0] rsp_red,
   output logic [SAMPLE_BITS-1:0] rsp_green,
   output logic [SAMPLE_BITS-1:0] rsp_blue,
   output logic                   rsp_frame_end
);

   logic                   valid_ff, valid_in;
   logic [SAMPLE_BITS-1:0] red_ff, red_in;
   logic [SAMPLE_BITS-1:0] green_ff, green_in;
   logic [SAMPLE_BITS-1:0] blue_ff, blue_in;
   logic                   frame_end_ff, frame_end_in;

   // s00 upper-left, s01 upper, s10 left, s11 current
   always_comb begin
      case (site)
         bnnd_pkg::SITE_GB_GREEN: begin
            red_in = s10; green_in = s00; blue_in = s01;
         end
         bnnd_pkg::SITE_BLUE: begin
            red_in = s11; green_in = s10; blue_in = s00;
         end
         bnnd_pkg::SITE_RED: begin
            red_in = s00; green_in = s10; blue_in = s11;
         end
         bnnd_pkg::SITE_RG_GREEN: begin
            red_in = s01; green_in = s00; blue_in = s10;
         end
         default: begin
            red_in = s10; green_in = s00; blue_in = s01;
         end
      endcase
      frame_end_in = frame_end;
   end

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         red_ff       <= red_in;
         green_ff     <= green_in;
         blue_ff      <= blue_in;
         frame_end_ff <= frame_end_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_red       = red_ff;
   assign rsp_green     = green_ff;
   assign rsp_blue      = blue_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

[sv/bayer_nearest_neighbor_demosaic_top.sv]
// ----------------------------------------------------------------------------
// bayer_nearest_neighbor_demosaic_top - nearest-neighbor Bayer demosaic
// G,B / R,G mosaic in raster order in, one RGB pixel per 2x2 window out.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake          payload
//   req_*     in         req_valid/ready    raw_sample
//   rsp_*     out        rsp_valid/ready    red, green, blue, frame_end
//   csr       in/out     APB psel/penable   line_length @0x0, line_count @0x4
//
// One request per clock sustained while rsp_ready stays high. A pixel goes
// valid on rsp_* once the request completing its window has passed the line
// store read and window register, then the result register.
// The line store is a single RAM, read and written at the
// same address on each accepted request (read-first), so no hazard exists.
// Synchronous reset clears counters and valids; the line store is not
// cleared, entries are always written a line before they are read.
// A stalled result holds; the window stage still drains requests that
// produce no pixel (first line, first column).
//
module bayer_nearest_neighbor_demosaic_top #(
   parameter int MAX_LINE_LENGTH = 4096,
   parameter int SAMPLE_BITS     = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [SAMPLE_BITS-1:0]              req_raw_sample,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [SAMPLE_BITS-1:0]              rsp_red,
   output logic [SAMPLE_BITS-1:0]              rsp_green,
   output logic [SAMPLE_BITS-1:0]              rsp_blue,
   output logic                                rsp_frame_end,
   // configuration port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bnnd_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [bnnd_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [bnnd_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   localparam int PIX_W = $clog2(MAX_LINE_LENGTH);

   // ---------------------------------------------------------------- CSRs
   logic [bnnd_pkg::CFG_W-1:0] line_length_ff, line_length_in;
   logic [bnnd_pkg::CFG_W-1:0] line_count_ff, line_count_in;
   bnnd_pkg::csr_reg_type      csr_sel;
   logic                       csr_wr;

   assign pready  = 1'b1;
   assign csr_sel = bnnd_pkg::csr_reg_type'(paddr[2]);
   assign csr_wr  = psel && penable && pwrite && pready;

   always_comb begin
      line_length_in = line_length_ff;
      line_count_in  = line_count_ff;
      if (csr_wr) begin
         case (csr_sel)
            bnnd_pkg::CSR_LINE_LENGTH: line_length_in = pwdata[bnnd_pkg::CFG_W-1:0];
            bnnd_pkg::CSR_LINE_COUNT:  line_count_in  = pwdata[bnnd_pkg::CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= bnnd_pkg::CFG_W'(bnnd_pkg::LINE_LENGTH_RST);
         line_count_ff  <= bnnd_pkg::CFG_W'(bnnd_pkg::LINE_COUNT_RST);
      end else begin
         line_length_ff <= line_length_in;
         line_count_ff  <= line_count_in;
      end
   end

   always_comb begin
      case (csr_sel)
         bnnd_pkg::CSR_LINE_LENGTH: prdata = bnnd_pkg::CSR_DATA_W'(line_length_ff);
         bnnd_pkg::CSR_LINE_COUNT:  prdata = bnnd_pkg::CSR_DATA_W'(line_count_ff);
         default:                   prdata = '0;
      endcase
   end

   // ------------------------------------------------------ request accept
   logic                   accept;
   logic                   win_valid_ff, win_valid_in;
   logic                   win_move;
   logic                   out_free;
   bnnd_pkg::pos_info_type pos_info;
   bnnd_pkg::pos_info_type win_info_ff;
   logic [PIX_W-1:0]       pixel_pos;
   logic [SAMPLE_BITS-1:0] upper;
   logic [SAMPLE_BITS-1:0] left_ff, left_in;
   logic [SAMPLE_BITS-1:0] win_cur_ff;
   logic [SAMPLE_BITS-1:0] win_left_ff;
   logic [SAMPLE_BITS-1:0] win_upper_left_ff;

   // window stage drains at once when it makes no pixel
   assign win_move  = win_valid_ff && (!win_info_ff.emit || out_free);
   assign req_ready = !win_valid_ff || win_move;
   assign accept    = req_valid && req_ready;

   bnnd_position #(
      .MAX_LINE_LENGTH (MAX_LINE_LENGTH)
   ) u_position (
      .clock       (clock),
      .reset       (reset),
      .advance     (accept),
      .line_length (line_length_ff),
      .line_count  (line_count_ff),
      .pixel_pos   (pixel_pos),
      .info        (pos_info)
   );

   // line store: upper sample comes out as the current one goes in
   bnnd_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (MAX_LINE_LENGTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (pixel_pos),
      .wr_data (req_raw_sample),
      .rd_en   (accept),
      .rd_addr (pixel_pos),
      .rd_data (upper)
   );

   // --------------------------------------------------------- window stage
   always_comb begin
      win_valid_in = win_valid_ff;
      left_in      = left_ff;
      if (accept) begin
         win_valid_in = 1'b1;
         left_in      = req_raw_sample;
      end else if (win_move) begin
         win_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_valid_ff <= 1'b0;
         left_ff      <= '0;
      end else begin
         win_valid_ff <= win_valid_in;
         left_ff      <= left_in;
      end
   end

   // RAM output still holds the previous request's upper sample here,
   // which is this request's upper-left
   always_ff @(posedge clock) begin
      if (reset) begin
         win_info_ff <= '0;
      end else if (accept) begin
         win_info_ff <= pos_info;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_cur_ff        <= req_raw_sample;
         win_left_ff       <= left_ff;
         win_upper_left_ff <= upper;
      end
   end

   // ------------------------------------------------------- result stage
   bnnd_select #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_select (
      .clock         (clock),
      .reset         (reset),
      .load          (win_move && win_info_ff.emit),
      .site          (win_info_ff.site),
      .frame_end     (win_info_ff.frame_end),
      .s00           (win_upper_left_ff),
      .s01           (upper),
      .s10           (win_left_ff),
      .s11           (win_cur_ff),
      .free          (out_free),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the nearest-neighbor Bayer demosaic
// Streams raw mosaic frames through the block, predicts each RGB pixel from
// a 2x2 window model kept in step with the requests, and checks every pixel
// field by field. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int LINE_DEPTH      = 4096;   // line store depth of the instance
   localparam int IDLE_PCT        = 38;     // percent of idle/stall cycles
   localparam int SETTLE_CYCLES   = 6;      // pipeline is two deep, margin on top
   localparam int RANDOM_REQUESTS = 450;
   localparam int WIDE_SAMPLES    = 40;     // samples sent on each wide line before its length is shrunk
   localparam int TALL_SAMPLES    = 100;    // samples before the tall frame ends
   localparam int CYCLE_LIMIT     = 600000;
   localparam int DIRECTED_ROWS   = 21;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_end;
   } pixel_type;

   typedef enum logic [1:0] {
      ROW_SET_LENGTH,
      ROW_SET_COUNT,
      ROW_SAMPLE
   } row_kind_type;

   // one directed step: a register write or a sample, with an optional
   // hand-written pixel where the answer is obvious
   typedef struct packed {
      row_kind_type kind;
      logic [12:0]  value;
      logic         typed;
      pixel_type    want;
   } stim_row_type;

   localparam pixel_type NO_PIXEL = '0;

   // Directed part:
   //  - 2x2 frames with registers below two (both act as two). Only the
   //    final sample emits, and it is a green site on a G,B line with
   //    frame_end set, so red/green/blue read straight off the samples.
   //  - a 3x3 frame that walks all four site colors, checked by the model.
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ROW_SET_LENGTH, 13'd0,  1'b0, NO_PIXEL},
      '{ROW_SET_COUNT,  13'd1,  1'b0, NO_PIXEL},
      '{ROW_SAMPLE,     13'h00, 1'b0, NO_PIXEL},
      '{ROW_SAMPLE,     13'hFF, 1'b0, NO_PIXEL},
      '{ROW_SAMPLE,     13'h5A, 1'b0, NO_PIXEL},
      '{ROW_SAMPLE,     13'h01, 1'b1, '{8'h5A, 8'h00, 8'hFF, 1'b1}},
      '{ROW_SAMPLE,     13'hFF, 1'b0, NO_PIXEL},
      '{ROW_SAMPLE,     13'h80, 1'b0, NO_PIXEL},
      '{ROW_SAMPLE,     13'h7F, 1'b0, NO_PIXEL},
      '{ROW_SAMPLE,     13'h00, 1'b1, '{8'h7F, 8'hFF, 8'h80, 1'b1}},
      '{ROW_SET_LENGTH, 13'd3,  1'b0, NO_PIXEL},
      '{ROW_SET_COUNT,  13'd3,  1'b0, NO_PIXEL},
      '{ROW_SAMPLE,     13'h11, 1'b0, NO_PIXEL},
      '{ROW_SAMPLE,     13'h22, 1'b0, NO_PIXEL},
      '{ROW_SAMPLE,     13'h33, 1'b0, NO_PIXEL},
      '{ROW_SAMPLE,     13'h44, 1'b0, NO_PIXEL},
      '{ROW_SAMPLE,     13'h55, 1'b0, NO_PIXEL},
      '{ROW_SAMPLE,     13'h66, 1'b0, NO_PIXEL},
      '{ROW_SAMPLE,     13'h77, 1'b0, NO_PIXEL},
      '{ROW_SAMPLE,     13'h88, 1'b0, NO_PIXEL},
      '{ROW_SAMPLE,     13'h99, 1'b0, NO_PIXEL}
   };

   // ---------------------------------------------------------------------
   // clock, reset and block I/O
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_valid      = 1'b0;
   logic                            req_ready;
   logic [7:0]                      req_raw_sample = '0;
   logic                            rsp_valid;
   logic                            rsp_ready      = 1'b0;
   logic [7:0]                      rsp_red;
   logic [7:0]                      rsp_green;
   logic [7:0]                      rsp_blue;
   logic                            rsp_frame_end;
   logic                            psel           = 1'b0;
   logic                            penable        = 1'b0;
   logic                            pwrite         = 1'b0;
   logic [bnnd_pkg::CSR_ADDR_W-1:0] paddr          = '0;
   logic [bnnd_pkg::CSR_DATA_W-1:0] pwdata         = '0;
   logic [bnnd_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   bayer_nearest_neighbor_demosaic_top #(
      .MAX_LINE_LENGTH(LINE_DEPTH),
      .SAMPLE_BITS    (8)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_raw_sample(req_raw_sample),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red       (rsp_red),
      .rsp_green     (rsp_green),
      .rsp_blue      (rsp_blue),
      .rsp_frame_end (rsp_frame_end),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   // ---------------------------------------------------------------------
   // bookkeeping
   // ---------------------------------------------------------------------
   pixel_type   expected_pixels [$];
   int unsigned error_count    = 0;
   int unsigned request_count  = 0;
   int unsigned pixel_count    = 0;
   int unsigned frame_count    = 0;
   int unsigned csr_writes     = 0;
   int unsigned cycle_count    = 0;
   bit          calm           = 1'b0;   // no idling on either side while set

   // ---------------------------------------------------------------------
   // window model: its own copy of the line store, window and counters
   // ---------------------------------------------------------------------
   logic [7:0]  prior_line [LINE_DEPTH];
   logic [7:0]  left_px   = '0;
   logic [7:0]  upleft_px = '0;
   logic [11:0] row_idx   = '0;
   logic [11:0] col_idx   = '0;
   logic [12:0] len_reg   = 13'(bnnd_pkg::LINE_LENGTH_RST);
   logic [12:0] cnt_reg   = 13'(bnnd_pkg::LINE_COUNT_RST);

   initial foreach (prior_line[k]) prior_line[k] = '0;

   // registers below two act as two, above the hardware size saturate
   function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
      if (v < bnnd_pkg::MIN_DIM) return bnnd_pkg::MIN_DIM;
      if (v > hi) return hi;
      return v;
   endfunction

   // advance the model by one sample; returns 1 when a pixel comes out
   function automatic bit demosaic_step(input logic [7:0] raw, output pixel_type px);
      int unsigned        span, depth, r, c;
      logic [7:0]         above;
      bit                 last_col, last_row, emit;
      bnnd_pkg::site_type site;
      span     = clamp_dim(len_reg, LINE_DEPTH);
      depth    = clamp_dim(cnt_reg, bnnd_pkg::MAX_LINE_COUNT);
      r        = row_idx;
      c        = col_idx;
      above    = prior_line[c];
      last_col = (c + 1 >= span);
      last_row = (r + 1 >= depth);
      emit     = (r >= 1) && (c >= 1);
      px       = '0;
      if (emit) begin
         // window: upleft above / left raw; output site is (r-1, c-1)
         site = bnnd_pkg::site_type'({~r[0], ~c[0]});
         case (site)
            bnnd_pkg::SITE_GB_GREEN: begin
               px.red = left_px;  px.green = upleft_px; px.blue = above;
            end
            bnnd_pkg::SITE_BLUE: begin
               px.red = raw;      px.green = left_px;   px.blue = upleft_px;
            end
            bnnd_pkg::SITE_RED: begin
               px.red = upleft_px; px.green = left_px;  px.blue = raw;
            end
            default: begin
               px.red = above;    px.green = upleft_px; px.blue = left_px;
            end
         endcase
         px.frame_end = last_col && last_row;
      end
      upleft_px     = above;
      prior_line[c] = raw;
      left_px       = raw;
      // counters past a shrunken limit wrap as if at the limit
      if (last_col) begin
         col_idx = '0;
         row_idx = last_row ? '0 : 12'(r + 1);
      end else begin
         col_idx = 12'(c + 1);
      end
      return emit;
   endfunction

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------
   function automatic logic [7:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // one request; typed_px replaces the model's answer for hand-checked rows
   task automatic send_sample(input logic [7:0] raw, input bit use_typed,
                              input pixel_type typed_px);
      pixel_type px;
      bit        emit;
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_raw_sample <= raw;
      do @(posedge clock); while (!req_ready);
      request_count++;
      emit = demosaic_step(raw, px);
      if (use_typed) px = typed_px;
      if (emit) expected_pixels = {expected_pixels, px};
      // valid stays up; the next call lowers or reloads it at the falling edge
   endtask

   task automatic send_samples(input int unsigned n);
      repeat (n) send_sample(pick_sample(), 1'b0, NO_PIXEL);
   endtask

   // stream until the model's counters wrap, k times over
   task automatic send_frames(input int unsigned k);
      repeat (k) begin
         do send_sample(pick_sample(), 1'b0, NO_PIXEL);
         while (row_idx != '0 || col_idx != '0);
      end
   endtask

   // stop requesting, wait for every pixel, then let the window stage drain
   // requests that make no pixel
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // register port
   // ---------------------------------------------------------------------
   task automatic csr_access(input bit wr, input bnnd_pkg::csr_reg_type sel,
                             input logic [bnnd_pkg::CSR_DATA_W-1:0] wdata,
                             output logic [bnnd_pkg::CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {sel, 2'b00};
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic check_register(input bnnd_pkg::csr_reg_type sel, input logic [12:0] want);
      logic [bnnd_pkg::CSR_DATA_W-1:0] rd;
      csr_access(1'b0, sel, '0, rd);
      if (rd !== bnnd_pkg::CSR_DATA_W'(want)) begin
         $error("%s: expected %0d, got %0d", sel.name(), want, rd);
         error_count++;
      end
   endtask

   // write a register with the block idle and keep the model in step
   task automatic configure(input bnnd_pkg::csr_reg_type sel, input logic [12:0] value);
      logic [bnnd_pkg::CSR_DATA_W-1:0] rd;
      settle_block();
      csr_access(1'b1, sel, bnnd_pkg::CSR_DATA_W'(value), rd);
      csr_writes++;
      if (sel == bnnd_pkg::CSR_LINE_LENGTH) len_reg = value;
      else cnt_reg = value;
      check_register(sel, value);
   endtask

   // ---------------------------------------------------------------------
   // result side: random stalls, pixel check against the oldest expectation
   // ---------------------------------------------------------------------
   always @(negedge clock) rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

   always @(posedge clock) begin : check_pixels
      pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected pixel: red %0h green %0h blue %0h frame_end %0b",
                   rsp_red, rsp_green, rsp_blue, rsp_frame_end);
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            pixel_count++;
            if (rsp_frame_end === 1'b1) frame_count++;
            if (rsp_red !== want.red) begin
               $error("red: expected %0h, got %0h", want.red, rsp_red);
               error_count++;
            end
            if (rsp_green !== want.green) begin
               $error("green: expected %0h, got %0h", want.green, rsp_green);
               error_count++;
            end
            if (rsp_blue !== want.blue) begin
               $error("blue: expected %0h, got %0h", want.blue, rsp_blue);
               error_count++;
            end
            if (rsp_frame_end !== want.frame_end) begin
               $error("frame_end: expected %0b, got %0b", want.frame_end, rsp_frame_end);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bayer_nearest_neighbor_demosaic_top verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------
   initial begin : main_sequence
      int unsigned random_start;
      int unsigned phase_no;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // registers come out of reset at 640 x 480
      check_register(bnnd_pkg::CSR_LINE_LENGTH, 13'(bnnd_pkg::LINE_LENGTH_RST));
      check_register(bnnd_pkg::CSR_LINE_COUNT, 13'(bnnd_pkg::LINE_COUNT_RST));

      // directed table
      foreach (directed_rows[k]) begin
         case (directed_rows[k].kind)
            ROW_SET_LENGTH: configure(bnnd_pkg::CSR_LINE_LENGTH, directed_rows[k].value);
            ROW_SET_COUNT:  configure(bnnd_pkg::CSR_LINE_COUNT, directed_rows[k].value);
            default: send_sample(directed_rows[k].value[7:0], directed_rows[k].typed,
                                 directed_rows[k].want);
         endcase
      end

      // Random frames at small random sizes (including register values below
      // two). Every phase ends on a frame boundary, so a larger line length
      // never reads store entries that this frame has not written yet.
      random_start = request_count;
      phase_no     = 0;
      while (request_count - random_start < RANDOM_REQUESTS) begin
         configure(bnnd_pkg::CSR_LINE_LENGTH, 13'($urandom_range(0, 20)));
         configure(bnnd_pkg::CSR_LINE_COUNT, 13'($urandom_range(0, 10)));
         calm = (phase_no == 2);
         if (phase_no == 1) begin
            // hold off mid-frame until every pixel is out, then resume
            send_samples($urandom_range(3, 12));
            settle_block();
         end
         send_frames($urandom_range(1, 3));
         calm = 1'b0;
         phase_no++;
      end

      // line count shrunk mid-frame: the current line is already past the
      // new limit, so it ends the frame
      configure(bnnd_pkg::CSR_LINE_LENGTH, 13'd3);
      configure(bnnd_pkg::CSR_LINE_COUNT, 13'd10);
      send_samples(19);
      configure(bnnd_pkg::CSR_LINE_COUNT, 13'd4);
      send_frames(2);

      // line length above the store depth saturates; shrinking it below the
      // current pixel ends the first line, and later ends the frame on the
      // last line, each time one pixel past the samples of the wide line
      configure(bnnd_pkg::CSR_LINE_LENGTH, 13'h1FFF);
      configure(bnnd_pkg::CSR_LINE_COUNT, 13'd2);
      send_samples(WIDE_SAMPLES);
      configure(bnnd_pkg::CSR_LINE_LENGTH, 13'd5);
      send_samples(1);
      configure(bnnd_pkg::CSR_LINE_LENGTH, 13'h1FFF);
      send_samples(WIDE_SAMPLES);
      configure(bnnd_pkg::CSR_LINE_LENGTH, 13'd5);
      send_frames(3);

      // line count above the limit saturates; a long run of lines with no
      // idling anywhere, then the count shrunk to end the frame
      configure(bnnd_pkg::CSR_LINE_LENGTH, 13'd2);
      configure(bnnd_pkg::CSR_LINE_COUNT, 13'd4100);
      calm = 1'b1;
      send_samples(TALL_SAMPLES);
      configure(bnnd_pkg::CSR_LINE_COUNT, 13'd2);
      send_frames(1);
      calm = 1'b0;

      settle_block();
      if (expected_pixels.size() != 0) begin
         $error("%0d pixels never arrived", expected_pixels.size());
         error_count++;
      end

      $display("run: %0d samples streamed, %0d pixels checked, %0d frame ends",
               request_count, pixel_count, frame_count);
      $display("run: %0d register writes, sizes below two, small frames, saturated limits",
               csr_writes);
      if (error_count == 0) begin
         $display("bayer_nearest_neighbor_demosaic_top verification clean");
      end else begin
         $display("bayer_nearest_neighbor_demosaic_top verification failed");
      end
      $finish;
   end

endmodule

[bayer_nearest_neighbor_demosaic_top.f]
sv/bnnd_pkg.sv
sv/bnnd_ram.sv
sv/bnnd_position.sv
sv/bnnd_select.sv
sv/bayer_nearest_neighbor_demosaic_top.sv
tb/tb_top.sv
